// File: sv/ierr_pkg.sv
// ----------------------------------------------------------------------------
// ierr_pkg
// Shared types, protocol constants and checksum helper of the ICMPv6 echo
// reply rewriter.
// ----------------------------------------------------------------------------
package ierr_pkg;

   localparam int WORD_W    = 64;
   localparam int BYTES_W   = 4;
   localparam int HDR_WORDS = 7;

   localparam logic [15:0] ETHERTYPE_IPV6  = 16'h86DD;
   localparam logic [7:0]  NEXT_HDR_ICMPV6 = 8'd58;
   localparam logic [7:0]  ECHO_REQUEST    = 8'd128;
   localparam logic [7:0]  ECHO_REPLY      = 8'd129;
   // ones' complement of the old type/code word (0x8000), and the new word itself
   localparam logic [15:0] CSUM_OLD_INV    = 16'h7FFF;
   localparam logic [15:0] CSUM_NEW        = 16'h8100;

   localparam logic [3:0]  FULL_BYTES      = 4'd8;
   localparam logic [3:0]  MIN_LAST_BYTES  = 4'd6;
   localparam logic [2:0]  LAST_HDR_POS    = 3'd6;
   localparam logic [2:0]  CSUM_POS        = 3'd7;

   typedef enum logic [1:0] {
      MODE_COLLECT = 2'd0,
      MODE_FORWARD = 2'd1,
      MODE_DISCARD = 2'd2,
      MODE_FLUSH   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      KIND_DATA = 2'd0,
      KIND_CSUM = 2'd1,
      KIND_DROP = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type             kind;
      logic [WORD_W-1:0]    word;
      logic [BYTES_W-1:0]   bytes;
      logic                 last;
   } item_type;

   // ones' complement 16-bit add with end-around carry
   function automatic logic [15:0] oc_add16(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      logic [16:0] t;
      s = {1'b0, a} + {1'b0, b};
      t = {1'b0, s[15:0]} + {16'd0, s[16]};
      return t[15:0];
   endfunction

endpackage

// File: sv/ierr_front.sv
// ----------------------------------------------------------------------------
// ierr_front
// Accepts frame words, holds the header, classifies the frame and issues
// work items (data, checksum word, drop) into the queue.
// ----------------------------------------------------------------------------
module ierr_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [63:0]           req_data_word,
   input  logic                  req_word_last,
   input  logic [3:0]            req_bytes_valid,
   output logic                  push_valid,
   input  logic                  push_ready,
   output ierr_pkg::item_type    push_item
);

   ierr_pkg::mode_type mode_ff, mode_in;
   logic [2:0]         pos_ff, pos_in;
   logic [2:0]         idx_ff, idx_in;
   logic [63:0]        hdr_ff [ierr_pkg::HDR_WORDS];
   logic [63:0]        w7_ff;
   logic [3:0]         cnt7_ff;
   logic               last7_ff;
   logic               hdr_we;
   logic               w7_we;
   logic               accept;
   logic [3:0]         cnt;
   logic               match;
   logic [7:0]         hb [ierr_pkg::HDR_WORDS*8];
   logic [7:0]         rb [ierr_pkg::HDR_WORDS*8];
   logic [63:0]        reply_words [ierr_pkg::HDR_WORDS];

   // byte count: only the last word may be short; zero or over eight is full
   assign cnt = (req_word_last && req_bytes_valid != 4'd0
                 && req_bytes_valid <= ierr_pkg::FULL_BYTES)
                ? req_bytes_valid : ierr_pkg::FULL_BYTES;

   assign match = hdr_ff[1][31:16] == ierr_pkg::ETHERTYPE_IPV6
               && hdr_ff[2][31:24] == ierr_pkg::NEXT_HDR_ICMPV6
               && req_data_word[15:8] == ierr_pkg::ECHO_REQUEST;

   // swap MACs and IPv6 addresses, set echo reply type
   always_comb begin
      for (int i = 0; i < ierr_pkg::HDR_WORDS*8; i++) begin
         hb[i] = hdr_ff[i/8][63-8*(i%8) -: 8];
      end
      for (int i = 0; i < ierr_pkg::HDR_WORDS*8; i++) begin
         if (i < 6) begin
            rb[i] = hb[i+6];
         end else if (i < 12) begin
            rb[i] = hb[i-6];
         end else if (i >= 22 && i < 38) begin
            rb[i] = hb[i+16];
         end else if (i >= 38 && i < 54) begin
            rb[i] = hb[i-16];
         end else if (i == 54) begin
            rb[i] = ierr_pkg::ECHO_REPLY;
         end else begin
            rb[i] = hb[i];
         end
      end
      for (int k = 0; k < ierr_pkg::HDR_WORDS; k++) begin
         for (int j = 0; j < 8; j++) begin
            reply_words[k][63-8*j -: 8] = rb[k*8+j];
         end
      end
   end

   always_comb begin
      mode_in    = mode_ff;
      pos_in     = pos_ff;
      idx_in     = idx_ff;
      hdr_we     = 1'b0;
      w7_we      = 1'b0;
      push_valid = 1'b0;
      push_item  = '{kind: ierr_pkg::KIND_DATA, word: req_data_word,
                     bytes: cnt, last: req_word_last};
      req_ready  = (mode_ff != ierr_pkg::MODE_FLUSH) && push_ready;
      accept     = req_valid && req_ready;
      case (mode_ff)
         ierr_pkg::MODE_FORWARD: begin
            push_valid = accept;
            if (accept && req_word_last) begin
               mode_in = ierr_pkg::MODE_COLLECT;
               pos_in  = 3'd0;
            end
         end
         ierr_pkg::MODE_DISCARD: begin
            push_item.kind = ierr_pkg::KIND_DROP;
            if (accept && req_word_last) begin
               push_valid = 1'b1;
               mode_in    = ierr_pkg::MODE_COLLECT;
               pos_in     = 3'd0;
            end
         end
         ierr_pkg::MODE_FLUSH: begin
            push_valid = 1'b1;
            if (idx_ff == ierr_pkg::CSUM_POS) begin
               push_item = '{kind: ierr_pkg::KIND_CSUM, word: w7_ff,
                             bytes: cnt7_ff, last: last7_ff};
            end else begin
               push_item = '{kind: ierr_pkg::KIND_DATA, word: reply_words[idx_ff],
                             bytes: ierr_pkg::FULL_BYTES, last: 1'b0};
            end
            if (push_ready) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == ierr_pkg::CSUM_POS) begin
                  mode_in = last7_ff ? ierr_pkg::MODE_COLLECT : ierr_pkg::MODE_FORWARD;
               end
            end
         end
         default: begin
            push_item.kind = ierr_pkg::KIND_DROP;
            if (accept) begin
               if (pos_ff != ierr_pkg::CSUM_POS) begin
                  hdr_we = 1'b1;
                  if (req_word_last) begin
                     push_valid = 1'b1;
                     mode_in    = ierr_pkg::MODE_COLLECT;
                     pos_in     = 3'd0;
                  end else if (pos_ff == ierr_pkg::LAST_HDR_POS && !match) begin
                     mode_in = ierr_pkg::MODE_DISCARD;
                     pos_in  = 3'd0;
                  end else begin
                     mode_in = ierr_pkg::MODE_COLLECT;
                     pos_in  = pos_ff + 3'd1;
                  end
               end else if (req_word_last && cnt < ierr_pkg::MIN_LAST_BYTES) begin
                  push_valid = 1'b1;
                  mode_in    = ierr_pkg::MODE_COLLECT;
                  pos_in     = 3'd0;
               end else begin
                  w7_we   = 1'b1;
                  mode_in = ierr_pkg::MODE_FLUSH;
                  idx_in  = 3'd0;
                  pos_in  = 3'd0;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= ierr_pkg::MODE_COLLECT;
         pos_ff  <= 3'd0;
         idx_ff  <= 3'd0;
      end else begin
         mode_ff <= mode_in;
         pos_ff  <= pos_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (hdr_we) begin
         hdr_ff[pos_ff] <= req_data_word;
      end
      if (w7_we) begin
         w7_ff    <= req_data_word;
         cnt7_ff  <= cnt;
         last7_ff <= req_word_last;
      end
   end

endmodule

// File: sv/ierr_queue.sv
// ----------------------------------------------------------------------------
// ierr_queue
// Small first-in first-out queue of work items between front and back.
// ----------------------------------------------------------------------------
module ierr_queue #(
   parameter int DEPTH = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   output logic                  push_ready,
   input  ierr_pkg::item_type    push_item,
   output logic                  pop_valid,
   input  logic                  pop_ready,
   output ierr_pkg::item_type    pop_item
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);

   ierr_pkg::item_type mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign push_ready = count_ff != CNT_W'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_item   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_MAX) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_MAX) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: sv/ierr_back.sv
// ----------------------------------------------------------------------------
// ierr_back
// Carries out work items: patches the checksum, forms drop results and
// holds each result in the output register.
// ----------------------------------------------------------------------------
module ierr_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  pop_valid,
   output logic                  pop_ready,
   input  ierr_pkg::item_type    pop_item,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [63:0]           rsp_out_word,
   output logic [3:0]            rsp_out_bytes,
   output logic                  rsp_out_end,
   output logic                  rsp_verdict
);

   logic        valid_ff, valid_in;
   logic [63:0] word_ff, word_in;
   logic [3:0]  bytes_ff, bytes_in;
   logic        end_ff, end_in;
   logic        verdict_ff, verdict_in;
   logic [15:0] csum_sum;
   logic        load;

   assign pop_ready = !valid_ff || rsp_ready;
   assign load      = pop_valid && pop_ready;

   // new = ~(~old + ~0x8000 + 0x8100)
   assign csum_sum = ierr_pkg::oc_add16(
                        ierr_pkg::oc_add16(~pop_item.word[63:48], ierr_pkg::CSUM_OLD_INV),
                        ierr_pkg::CSUM_NEW);

   always_comb begin
      word_in    = pop_item.word;
      bytes_in   = pop_item.bytes;
      end_in     = pop_item.last;
      verdict_in = 1'b0;
      case (pop_item.kind)
         ierr_pkg::KIND_CSUM: begin
            word_in = {~csum_sum, pop_item.word[47:0]};
         end
         ierr_pkg::KIND_DROP: begin
            word_in    = '0;
            bytes_in   = '0;
            end_in     = 1'b1;
            verdict_in = 1'b1;
         end
         default: begin
            word_in = pop_item.word;
         end
      endcase
      valid_in = load ? 1'b1 : (valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff    <= word_in;
         bytes_ff   <= bytes_in;
         end_ff     <= end_in;
         verdict_ff <= verdict_in;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_out_word  = word_ff;
   assign rsp_out_bytes = bytes_ff;
   assign rsp_out_end   = end_ff;
   assign rsp_verdict   = verdict_ff;

endmodule

// File: sv/icmpv6_echo_reply_rewriter.sv
// ----------------------------------------------------------------------------
// icmpv6_echo_reply_rewriter
// Turns ICMPv6 echo requests, streamed as 64-bit words, into echo replies.
// ----------------------------------------------------------------------------
// Frames arrive one big-endian 64-bit word per request, first byte in the top
// byte lane. The first seven words are held; the seventh decides whether the
// frame is an IPv6 ICMPv6 echo request and the eighth whether it is at least
// 62 bytes long. A reply frame leaves with MAC and IPv6 addresses swapped, the
// type set to echo reply and the checksum patched incrementally; the eight
// header results all leave after the eighth word is taken, later words pass
// one for one. Any other frame yields one drop result (verdict high, no data)
// on its last word. Words are taken at one per cycle while the queue has room;
// on the eighth word of a reply frame the front stops taking requests while it
// issues the rewritten header into the queue, one word a cycle while the queue
// has room. Other frames cause no such pause. A forwarded word or a drop result
// is written into the queue when its request is taken and reaches rsp_valid
// when the output register loads it from there. The queue (QUEUE_DEPTH items)
// lets requests be taken while a result still waits for rsp_ready and absorbs
// short stalls on the result side.
// ----------------------------------------------------------------------------
module icmpv6_echo_reply_rewriter #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_data_word,
   input  logic        req_word_last,
   input  logic [3:0]  req_bytes_valid,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_out_word,
   output logic [3:0]  rsp_out_bytes,
   output logic        rsp_out_end,
   output logic        rsp_verdict
);

   // work items from the classifier into the queue
   logic               push_valid;
   logic               push_ready;
   ierr_pkg::item_type push_item;
   // work items from the queue into the output stage
   logic               pop_valid;
   logic               pop_ready;
   ierr_pkg::item_type pop_item;

   // front: hold the header, classify, issue rewritten header words
   ierr_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_word   (req_data_word),
      .req_word_last   (req_word_last),
      .req_bytes_valid (req_bytes_valid),
      .push_valid      (push_valid),
      .push_ready      (push_ready),
      .push_item       (push_item)
   );

   // decouple the two sides so each may stall on its own
   ierr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   // back: patch the checksum, form drop results, register the output
   ierr_back u_back (
      .clock         (clock),
      .reset         (reset),
      .pop_valid     (pop_valid),
      .pop_ready     (pop_ready),
      .pop_item      (pop_item),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_word  (rsp_out_word),
      .rsp_out_bytes (rsp_out_bytes),
      .rsp_out_end   (rsp_out_end),
      .rsp_verdict   (rsp_verdict)
   );

endmodule

// File: tb/echo_reply_sb_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// echo_reply_sb_pkg
// Expected-response scoreboard for the ICMPv6 echo reply rewriter.
// ----------------------------------------------------------------------------
// Tracks the frame state of the rewriter from the accepted request words and
// queues the responses each word should cause; responses are checked in order.
// ----------------------------------------------------------------------------
package echo_reply_sb_pkg;

   typedef struct {
      logic [63:0] word;
      logic [3:0]  bytes;
      logic        frame_end;
      logic        verdict;
   } reply_beat_type;

   class echo_reply_scoreboard;
      logic [63:0]        header_words [ierr_pkg::HDR_WORDS];
      logic [3:0]         next_pos;
      ierr_pkg::mode_type mode;
      reply_beat_type     expected_beats [$];
      int                 errors;
      int                 replies;
      int                 drops;
      int                 checked;

      function new();
         foreach (header_words[i]) header_words[i] = '0;
         next_pos = '0;
         mode     = ierr_pkg::MODE_COLLECT;
         errors   = 0;
         replies  = 0;
         drops    = 0;
         checked  = 0;
      endfunction

      function int pending();
         return expected_beats.size();
      endfunction

      function logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
         logic [16:0] s;
         s = {1'b0, a} + {1'b0, b};
         s = {1'b0, s[15:0]} + {16'd0, s[16]};
         return s[15:0];
      endfunction

      function void push_beat(input logic [63:0] w, input logic [3:0] n, input logic fe,
                              input logic vd);
         reply_beat_type b;
         b.word      = w;
         b.bytes     = n;
         b.frame_end = fe;
         b.verdict   = vd;
         expected_beats.push_back(b);
      endfunction

      function void restart_with_drop();
         push_beat('0, 4'd0, 1'b1, 1'b1);
         drops++;
         next_pos = '0;
         mode     = ierr_pkg::MODE_COLLECT;
      endfunction

      // Advance the frame state by one accepted request word.
      function void note_request(input logic [63:0] w, input logic l, input logic [3:0] bv);
         logic [3:0]  cnt;
         logic [7:0]  hb [ierr_pkg::HDR_WORDS*8];
         logic [7:0]  t;
         logic [63:0] ow;
         logic [15:0] csum;
         logic        is_echo;
         int          p;
         cnt = (l && bv != 4'd0 && bv <= ierr_pkg::FULL_BYTES) ? bv : ierr_pkg::FULL_BYTES;
         if (mode == ierr_pkg::MODE_FORWARD) begin
            push_beat(w, cnt, l, 1'b0);
            if (l) begin
               mode     = ierr_pkg::MODE_COLLECT;
               next_pos = '0;
            end
            return;
         end
         if (mode == ierr_pkg::MODE_DISCARD) begin
            if (l) restart_with_drop();
            return;
         end
         p = int'(next_pos);
         if (p < ierr_pkg::HDR_WORDS) begin
            header_words[p] = w;
            is_echo = header_words[1][31:16] == ierr_pkg::ETHERTYPE_IPV6 &&
                      header_words[2][31:24] == ierr_pkg::NEXT_HDR_ICMPV6 &&
                      header_words[6][15:8] == ierr_pkg::ECHO_REQUEST;
            if (l) begin
               restart_with_drop();
            end else if (p == ierr_pkg::HDR_WORDS - 1 && !is_echo) begin
               mode     = ierr_pkg::MODE_DISCARD;
               next_pos = '0;
            end else begin
               next_pos = 4'(p + 1);
               mode     = ierr_pkg::MODE_COLLECT;
            end
            return;
         end
         if (l && cnt < ierr_pkg::MIN_LAST_BYTES) begin
            restart_with_drop();
            return;
         end
         // swap MACs and IPv6 addresses, turn the request into a reply
         for (int i = 0; i < ierr_pkg::HDR_WORDS*8; i++)
            hb[i] = header_words[i/8][63-8*(i%8) -: 8];
         for (int i = 0; i < 6; i++) begin
            t = hb[i]; hb[i] = hb[i+6]; hb[i+6] = t;
         end
         for (int i = 0; i < 16; i++) begin
            t = hb[22+i]; hb[22+i] = hb[38+i]; hb[38+i] = t;
         end
         hb[54] = ierr_pkg::ECHO_REPLY;
         for (int k = 0; k < ierr_pkg::HDR_WORDS; k++) begin
            ow = '0;
            for (int i = 0; i < 8; i++) ow = {ow[55:0], hb[k*8+i]};
            push_beat(ow, ierr_pkg::FULL_BYTES, 1'b0, 1'b0);
         end
         csum = ~ones_add(ones_add(~w[63:48], ierr_pkg::CSUM_OLD_INV),
                          ierr_pkg::CSUM_NEW);
         push_beat({csum, w[47:0]}, cnt, l, 1'b0);
         replies++;
         next_pos = '0;
         mode     = l ? ierr_pkg::MODE_COLLECT : ierr_pkg::MODE_FORWARD;
      endfunction

      function void check_response(input logic [63:0] w, input logic [3:0] n, input logic fe,
                                   input logic vd);
         reply_beat_type b;
         if (expected_beats.size() == 0) begin
            $error("unexpected response: out_word %h out_bytes %0d out_end %0d verdict %0d",
                   w, n, fe, vd);
            errors++;
            return;
         end
         b = expected_beats.pop_front();
         checked++;
         if (w !== b.word) begin
            $error("out_word: expected %h, got %h", b.word, w);
            errors++;
         end
         if (n !== b.bytes) begin
            $error("out_bytes: expected %0d, got %0d", b.bytes, n);
            errors++;
         end
         if (fe !== b.frame_end) begin
            $error("out_end: expected %0d, got %0d", b.frame_end, fe);
            errors++;
         end
         if (vd !== b.verdict) begin
            $error("verdict: expected %0d, got %0d", b.verdict, vd);
            errors++;
         end
      endfunction
   endclass

endpackage

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench of the ICMPv6 echo reply rewriter.
// ----------------------------------------------------------------------------
// Streams Ethernet frames word by word into the rewriter: echo requests of
// various lengths, requests cut short inside the header or below 62 bytes,
// frames with a wrong ethertype, next header or ICMPv6 type, and plain noise.
// Every accepted request word is fed to a scoreboard that predicts the
// responses; every accepted response is checked against the oldest one.
// Both sides idle at random, the receiver once holds off for a long stretch
// and the sender waits for the block to drain after the directed frames and once mid-run.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int CLK_PERIOD      = 10;
   localparam int RESET_CYCLES    = 12;
   localparam int ITEMS_TARGET    = 350;
   localparam int MAX_FRAME_WORDS = 40;
   localparam int LONG_HOLD       = 200;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int TAIL_CYCLES     = 20;

   typedef enum int {
      FRAME_ECHO,
      FRAME_BAD_ETHERTYPE,
      FRAME_BAD_NEXT_HDR,
      FRAME_BAD_TYPE,
      FRAME_NOISE
   } frame_kind_type;

   typedef enum int {
      FILL_RANDOM,
      FILL_ONES,
      FILL_ZEROS
   } fill_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [63:0] req_data_word;
   logic        req_word_last;
   logic [3:0]  req_bytes_valid;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [63:0] rsp_out_word;
   logic [3:0]  rsp_out_bytes;
   logic        rsp_out_end;
   logic        rsp_verdict;

   echo_reply_sb_pkg::echo_reply_scoreboard sb;

   int words_sent;
   int frames_sent;
   int cycle_count;
   // idle_on enables random gaps on both sides; stall_request asks the
   // receiver for one long hold-off, counted down in its own process
   bit idle_on;
   int stall_request;

   icmpv6_echo_reply_rewriter i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_word   (req_data_word),
      .req_word_last   (req_word_last),
      .req_bytes_valid (req_bytes_valid),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_word    (rsp_out_word),
      .rsp_out_bytes   (rsp_out_bytes),
      .rsp_out_end     (rsp_out_end),
      .rsp_verdict     (rsp_verdict)
   );

   initial clock = 1'b0;
   always #(CLK_PERIOD/2) clock = ~clock;

   // Bound the run; a hang or a lost response ends here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, sb.pending());
         $display("icmpv6_echo_reply_rewriter: mismatch");
         $finish;
      end
   end

   // Check every response taken at a rising edge against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_response(rsp_out_word, rsp_out_bytes, rsp_out_end, rsp_verdict);
   end

   // Receiver: decide rsp_ready at each falling edge. Mostly ready, short
   // stalls now and then, a few long ones; only the requested hold-off while idling is off.
   initial begin : result_sink
      int hold;
      int r;
      hold      = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_request != 0) begin
            hold          = stall_request;
            stall_request = 0;
         end
         if (hold > 0) begin
            rsp_ready <= 1'b0;
            hold--;
         end else if (!idle_on) begin
            rsp_ready <= 1'b1;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 65) begin
               rsp_ready <= 1'b1;
            end else begin
               rsp_ready <= 1'b0;
               hold = (r < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
            end
         end
      end
   end

   // Offer one request word at a falling edge and hold it until the block
   // takes it; then maybe leave a gap before the next one.
   task automatic push_word(input logic [63:0] w, input logic l, input logic [3:0] bv);
      int r;
      int gap;
      @(negedge clock);
      req_valid       <= 1'b1;
      req_data_word   <= w;
      req_word_last   <= l;
      req_bytes_valid <= bv;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(w, l, bv);
      words_sent++;
      gap = 0;
      if (idle_on) begin
         r = $urandom_range(0, 99);
         if (r >= 94)      gap = $urandom_range(10, 40);
         else if (r >= 60) gap = $urandom_range(1, 3);
      end
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stop offering requests until every expected response has come back.
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // Build one frame and stream it. Header fields are planted at their byte
   // lanes: ethertype in bytes 12..13, next header in byte 20, ICMPv6 type in
   // byte 54, checksum in bytes 56..57.
   task automatic send_frame(input frame_kind_type kind, input int n_words,
                             input logic [3:0] last_bv, input fill_type fill);
      logic [63:0] fw [MAX_FRAME_WORDS];
      logic [15:0] specials [5];
      int          i;
      specials = '{16'h0000, 16'hFFFF, 16'h8000, 16'h7EFF, 16'hFEFF};
      for (i = 0; i < n_words; i++) begin
         case (fill)
            FILL_ONES:  fw[i] = '1;
            FILL_ZEROS: fw[i] = '0;
            default:    fw[i] = {$urandom, $urandom};
         endcase
      end
      if (kind != FRAME_NOISE) begin
         if (n_words > 1) fw[1][31:16] = ierr_pkg::ETHERTYPE_IPV6;
         if (n_words > 2) fw[2][31:24] = ierr_pkg::NEXT_HDR_ICMPV6;
         if (n_words > 6) fw[6][15:8] = ierr_pkg::ECHO_REQUEST;
         // push the checksum patch through its wrap-around corners now and then
         if (n_words > 7 && $urandom_range(0, 3) == 0)
            fw[7][63:48] = specials[$urandom_range(0, 4)];
         case (kind)
            FRAME_BAD_ETHERTYPE:
               if (n_words > 1)
                  fw[1][31:16] = fw[1][31:16] ^ 16'($urandom_range(1, 16'hFFFF));
            FRAME_BAD_NEXT_HDR:
               if (n_words > 2)
                  fw[2][31:24] = fw[2][31:24] ^ 8'($urandom_range(1, 255));
            FRAME_BAD_TYPE:
               if (n_words > 6) begin
                  if ($urandom_range(0, 1) == 0) fw[6][15:8] = ierr_pkg::ECHO_REPLY;
                  else fw[6][15:8] = fw[6][15:8] ^ 8'($urandom_range(1, 255));
               end
            default: ;
         endcase
      end
      for (i = 0; i < n_words; i++) begin
         if (i == n_words - 1) push_word(fw[i], 1'b1, last_bv);
         else push_word(fw[i], 1'b0, 4'($urandom_range(0, 15)));
      end
      frames_sent++;
   endtask

   initial begin : stimulus
      int             pick;
      int             len;
      int             r;
      logic [3:0]     lbv;
      frame_kind_type kind;
      fill_type       fill;
      sb              = new();
      words_sent      = 0;
      frames_sent     = 0;
      cycle_count     = 0;
      idle_on         = 1'b1;
      stall_request   = 0;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_data_word   = '0;
      req_word_last   = 1'b0;
      req_bytes_valid = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: a reply with a forwarded tail whose count of zero means a
      // full word, a request one byte too short, a wrong ICMPv6 type and a
      // frame that ends on its first word.
      send_frame(FRAME_ECHO, 9, 4'd0, FILL_ONES);
      send_frame(FRAME_ECHO, 8, 4'd5, FILL_ZEROS);
      send_frame(FRAME_BAD_TYPE, 8, 4'd8, FILL_RANDOM);
      send_frame(FRAME_ECHO, 1, 4'd15, FILL_ONES);
      drain_results();

      // Random: mostly well-formed echo requests, the rest broken or noise.
      while (words_sent < ITEMS_TARGET) begin
         if (frames_sent % 8 == 0) idle_on = ($urandom_range(0, 3) != 0);
         if (frames_sent == 12) begin
            // hold the receiver off and keep the sender busy so the queue fills
            stall_request = LONG_HOLD;
            idle_on       = 1'b0;
         end
         if (frames_sent == 24) drain_results();
         r    = $urandom_range(0, 9);
         fill = (r == 0) ? FILL_ONES : (r == 1) ? FILL_ZEROS : FILL_RANDOM;
         len  = ($urandom_range(0, 19) == 0) ? $urandom_range(20, MAX_FRAME_WORDS)
                                             : $urandom_range(8, 12);
         r    = $urandom_range(0, 19);
         lbv  = (r < 14) ? 4'($urandom_range(6, 8)) :
                (r < 16) ? 4'd0 :
                (r < 18) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(1, 5));
         pick = $urandom_range(0, 99);
         kind = FRAME_ECHO;
         if (pick < 55) begin
            kind = FRAME_ECHO;
         end else if (pick < 65) begin
            len = 8;
            lbv = 4'($urandom_range(1, 5));
         end else if (pick < 73) begin
            len = $urandom_range(1, 7);
            lbv = 4'($urandom_range(0, 15));
         end else if (pick < 80) begin
            kind = FRAME_BAD_ETHERTYPE;
         end else if (pick < 87) begin
            kind = FRAME_BAD_NEXT_HDR;
         end else if (pick < 94) begin
            kind = FRAME_BAD_TYPE;
         end else begin
            kind = FRAME_NOISE;
            len  = $urandom_range(1, 12);
            lbv  = 4'($urandom_range(0, 15));
         end
         send_frame(kind, len, lbv, fill);
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("run covered %0d request words in %0d frames: %0d echo replies, %0d drops",
               words_sent, frames_sent, sb.replies, sb.drops);
      $display("%0d responses checked, %0d errors", sb.checked, sb.errors);
      if (sb.errors == 0)
         $display("icmpv6_echo_reply_rewriter: match");
      else
         $display("icmpv6_echo_reply_rewriter: mismatch");
      $finish;
   end

endmodule

// File: icmpv6_echo_reply_rewriter.f
sv/ierr_pkg.sv
sv/ierr_front.sv
sv/ierr_queue.sv
sv/ierr_back.sv
sv/icmpv6_echo_reply_rewriter.sv
tb/echo_reply_sb_pkg.sv
tb/tb_top.sv
